// ===== rtl/sts_pkg.sv =====
// Shared constants and types for the sorted table binary search block.
// No dependencies; every other file in rtl/ imports this package.
package sts_pkg;

  // Fixed field widths of the item and result beats.
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned COUNT_W    = 11;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register word index of entry_count (byte address 4 * index).
  localparam logic [CFG_ADDR_W-3:0] REG_ENTRY_COUNT = 1'b0;

  // Command codes carried by in_command.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // One search result.
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } sts_result_t;

endpackage

// ===== rtl/sts_cfg_regs.sv =====
// APB-style configuration register file holding entry_count.
// Depends on sts_pkg for address, data and count widths.
module sts_cfg_regs
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [COUNT_W-1:0]    entry_count
);

  logic [COUNT_W-1:0] entry_count_r;
  logic               sel_count;

  // Word select; the low two bits are the byte offset within a word.
  assign sel_count  = (cfg_paddr[CFG_ADDR_W-1:2] == REG_ENTRY_COUNT);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_count) begin
      entry_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_count) begin
      cfg_prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, entry_count_r};
    end
  end

  assign entry_count = entry_count_r;

endmodule

// ===== rtl/sts_table_mem.sv =====
// Single-port synchronous table memory with a registered read port.
// Depends on sts_pkg only through the shared import convention.
module sts_table_mem
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sts_search_ctrl.sv =====
// Search sequencer: accepts beats, drives the table memory and holds results.
// Depends on sts_pkg for field widths, command codes and the result type.
module sts_search_ctrl
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned ADDR_W      = 10,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COUNT_W-1:0]     entry_count,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [INDEX_W-1:0]     in_entry_index,
  input  logic [FIELD_W-1:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [INDEX_W-1:0]     out_position,
  output logic                   mem_en,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_addr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  input  logic [VALUE_WIDTH-1:0] mem_rdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;      // first index still in range
  logic [CNT_W-1:0]       end_r, end_nxt;    // one past the last index in range
  logic [ADDR_W-1:0]      mid_r, mid_nxt;    // index read in the previous cycle
  logic [VALUE_WIDTH-1:0] target_r, target_nxt;
  sts_result_t            res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sts_result_t            out_r, out_nxt;

  logic                   accept;
  logic [63:0]            value_ext;
  logic [VALUE_WIDTH-1:0] value_trunc;
  logic [31:0]            index_ext;
  logic                   index_ok;
  logic [31:0]            count_ext;
  logic [CNT_W-1:0]       count_sat;
  logic [CNT_W:0]         first_sum;
  logic [CNT_W-1:0]       mid_cnt;
  logic [CNT_W:0]         sum_low, sum_high;
  logic                   low_nonempty, high_nonempty;
  logic                   hit, below;
  logic                   out_free;
  logic                   done;
  sts_result_t            done_res;
  logic [31:0]            mid_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  // The field is a 32-bit signed number; its low VALUE_WIDTH bits are kept.
  assign value_ext   = {{32{in_value[FIELD_W-1]}}, in_value};
  assign value_trunc = value_ext[VALUE_WIDTH-1:0];

  assign index_ext = {{(32-INDEX_W){1'b0}}, in_entry_index};
  assign index_ok  = (index_ext < TABLE_DEPTH);

  // Saturate the count at the table depth.
  assign count_ext = {{(32-COUNT_W){1'b0}}, entry_count};
  always_comb begin
    if (count_ext > TABLE_DEPTH) begin
      count_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      count_sat = count_ext[CNT_W-1:0];
    end
  end
  assign first_sum = {1'b0, count_sat} - {{CNT_W{1'b0}}, 1'b1};

  // Both possible next midpoints are formed from registers alone; the compare
  // result only selects between them.
  assign mid_cnt       = {{(CNT_W-ADDR_W){1'b0}}, mid_r};
  assign sum_low       = {1'b0, lo_r} + {1'b0, mid_cnt} - {{CNT_W{1'b0}}, 1'b1};
  assign sum_high      = {1'b0, mid_cnt} + {1'b0, end_r};
  assign low_nonempty  = (lo_r < mid_cnt);
  assign high_nonempty = ((mid_cnt + CNT_W'(1)) < end_r);
  assign hit           = (mem_rdata == target_r);
  assign below         = ($signed(target_r) < $signed(mem_rdata));

  assign mid_ext = {{(32-ADDR_W){1'b0}}, mid_r};

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = mid_r;
    mem_wdata     = value_trunc;
    done          = 1'b0;
    done_res      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            mem_en   = index_ok;
            mem_we   = 1'b1;
            mem_addr = index_ext[ADDR_W-1:0];
          end else begin
            target_nxt = value_trunc;
            lo_nxt     = '0;
            end_nxt    = count_sat;
            if (count_sat == '0) begin
              res_nxt   = '0;
              state_nxt = ST_HOLD;
            end else begin
              mid_nxt   = first_sum[ADDR_W:1];
              mem_en    = 1'b1;
              mem_addr  = first_sum[ADDR_W:1];
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (hit) begin
          done              = 1'b1;
          done_res.found    = 1'b1;
          done_res.position = mid_ext[INDEX_W-1:0];
        end else if (below) begin
          end_nxt = mid_cnt;
          if (low_nonempty) begin
            mid_nxt  = sum_low[ADDR_W:1];
            mem_en   = 1'b1;
            mem_addr = sum_low[ADDR_W:1];
          end else begin
            done = 1'b1;
          end
        end else begin
          lo_nxt = mid_cnt + CNT_W'(1);
          if (high_nonempty) begin
            mid_nxt  = sum_high[ADDR_W:1];
            mem_en   = 1'b1;
            mem_addr = sum_high[ADDR_W:1];
          end else begin
            done = 1'b1;
          end
        end
        if (done) begin
          if (out_free) begin
            out_nxt       = done_res;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            res_nxt   = done_res;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lo_r        <= '0;
      end_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lo_r        <= lo_nxt;
      end_r       <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_r.found;
  assign out_position = out_r.position;

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table binary search: a write beat stores one entry, a search beat
// returns one result. A search issues its probes one at a time, as the single
// table read port allows. One item is in work at a time; a finished result
// waits in a hold register while the output register is still full.
// Reset (rst_n, synchronous) clears control state and entry_count; the table
// itself is not cleared and holds undefined data until written.
module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [INDEX_W-1:0]    in_entry_index,
  input  logic [FIELD_W-1:0]    in_value,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [INDEX_W-1:0]    out_position
);

  // Address width of the table, and width of a range bound, which must also
  // hold the depth itself as an exclusive end.
  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = ADDR_W + 1;

  logic [COUNT_W-1:0]     entry_count;
  logic                   mem_en;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // The user must write the entry count over the config port only while idle; not enforced.
  sts_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .entry_count (entry_count)
  );

  // With a nonzero count the sequencer issues the first probe in the cycle a
  // search beat is accepted. Each following cycle it compares the returned
  // entry with the target and, on a mismatch with the range not yet empty,
  // issues the next probe; two precomputed midpoints let the compare only select.
  sts_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .entry_count    (entry_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .mem_en         (mem_en),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .mem_rdata      (mem_rdata)
  );

  // Table storage: one access per cycle, with read data in the next cycle.
  sts_table_mem #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (VALUE_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
